// ===== design/dpf_pkg.sv =====
// Package for the display-link packet framer: action codes, framing constants,
// the result-run type and the header ECC function. No dependencies.
package dpf_pkg;

  localparam int unsigned RunDepth = 8;
  localparam int unsigned RunIdxW  = $clog2(RunDepth);

  localparam logic [1:0] ACT_SHORT   = 2'd0;
  localparam logic [1:0] ACT_LONG    = 2'd1;
  localparam logic [1:0] ACT_PAYLOAD = 2'd2;

  localparam logic [7:0] SOT_BYTE = 8'hB8;
  localparam logic [7:0] END_BYTE = 8'hFF;
  localparam logic [7:0] CRC_BYTE = 8'h00;

  localparam logic [23:0] ECC_MASK [6] = '{
    24'hF12CB7, 24'hF2555B, 24'h749A6D, 24'hB8E38E, 24'hDF03F0, 24'hEFFC00
  };

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  data_type;
    logic [15:0] word_count;
    logic [7:0]  data_byte;
    logic [7:0]  second_byte;
  } dpf_item_t;

  // One run of result bytes; byte 0 goes out first.
  typedef struct packed {
    logic [RunDepth-1:0][7:0] bytes;
    logic [RunDepth-1:0]      ends;
    logic [RunIdxW-1:0]       last;
  } dpf_run_t;

  // 6-bit Hamming ECC over the 24 header bits, returned as a byte.
  function automatic logic [7:0] header_ecc(input logic [7:0] b0, input logic [7:0] b1,
                                             input logic [7:0] b2);
    logic [23:0] hdr;
    logic [7:0]  ecc;
    hdr = {b2, b1, b0};
    ecc = '0;
    for (int i = 0; i < 6; i++) begin
      ecc[i] = ^(hdr & ECC_MASK[i]);
    end
    return ecc;
  endfunction

endpackage

// ===== design/dpf_in_if.sv =====
// Input channel of the packet framer: valid/ready plus the item fields.
// Depends on nothing.
interface dpf_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [7:0]  data_type;
  logic [15:0] word_count;
  logic [7:0]  data_byte;
  logic [7:0]  second_byte;

  modport source (output valid, action, data_type, word_count, data_byte, second_byte,
                  input ready);
  modport sink   (input valid, action, data_type, word_count, data_byte, second_byte,
                  output ready);
endinterface

// ===== design/dpf_out_if.sv =====
// Output channel of the packet framer: valid/ready plus one stream byte and flags.
// Depends on nothing.
interface dpf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       packet_end;
  logic       run_last;

  modport source (output valid, out_byte, packet_end, run_last, input ready);
  modport sink   (input valid, out_byte, packet_end, run_last, output ready);
endinterface

// ===== design/dsi_packet_framer_ecc.sv =====
// Top level of the display-link packet framer with header ECC.
// Depends on dpf_pkg, dpf_in_if, dpf_out_if, dpf_builder, dpf_serializer.
//
//  channel | dir | handshake      | word
//  --------+-----+----------------+----------------------------------------------
//  in_i    | in  | valid/ready    | action, data_type, word_count, data_byte,
//          |     |                | second_byte
//  out_o   | out | valid/ready    | out_byte, packet_end, run_last
//
// An accepted item is framed combinationally and its whole run of bytes (0 to
// 8) lands in the result register in the same edge; bytes then leave one per
// cycle while out_o.ready is high. A payload byte mid-packet is a run of one
// byte, a short packet 6 bytes, a long header 5, and a trailer adds 3 bytes.
// in_i.ready is high when the result register is empty or its final byte is
// taken this cycle, so a stalled out_o holds back the input.
// Reset clears the packet state and empties the result register.
module dsi_packet_framer_ecc
  import dpf_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  dpf_in_if.sink    in_i,
  dpf_out_if.source out_o
);

  dpf_item_t item;
  dpf_run_t  run;
  logic      has_run;
  logic      accept;
  logic      free;

  assign item.action      = in_i.action;
  assign item.data_type   = in_i.data_type;
  assign item.word_count  = in_i.word_count;
  assign item.data_byte   = in_i.data_byte;
  assign item.second_byte = in_i.second_byte;

  // items with no result (stray payload, unused code) are taken only when the
  // result register can take a run too; this keeps ready independent of data
  assign in_i.ready = free;
  assign accept     = in_i.valid && free;

  dpf_builder u_builder (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .item_i    (item),
    .has_run_o (has_run),
    .run_o     (run)
  );

  dpf_serializer u_serializer (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (accept && has_run),
    .run_i  (run),
    .free_o (free),
    .out_o  (out_o)
  );

endmodule

// ===== design/dpf_builder.sv =====
// Packet state and run builder: turns one accepted item into a run of bytes.
// Depends on dpf_pkg.
module dpf_builder
  import dpf_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      accept_i,
  input  dpf_item_t item_i,
  output logic      has_run_o,
  output dpf_run_t  run_o
);

  logic [15:0] remaining_q, remaining_d;
  logic        open_q, open_d;
  logic [15:0] rem_dec;

  assign rem_dec = remaining_q - 16'd1;

  always_comb begin
    remaining_d = remaining_q;
    open_d      = open_q;
    has_run_o   = 1'b0;
    run_o.bytes = '0;
    run_o.ends  = '0;
    run_o.last  = '0;
    case (item_i.action)
      ACT_SHORT: begin
        has_run_o      = 1'b1;
        open_d         = 1'b0;
        remaining_d    = '0;
        run_o.bytes[0] = SOT_BYTE;
        run_o.bytes[1] = item_i.data_type;
        run_o.bytes[2] = item_i.data_byte;
        run_o.bytes[3] = item_i.second_byte;
        run_o.bytes[4] = header_ecc(item_i.data_type, item_i.data_byte, item_i.second_byte);
        run_o.bytes[5] = END_BYTE;
        run_o.ends[5]  = 1'b1;
        run_o.last     = RunIdxW'(5);
      end
      ACT_LONG: begin
        has_run_o      = 1'b1;
        run_o.bytes[0] = SOT_BYTE;
        run_o.bytes[1] = item_i.data_type;
        run_o.bytes[2] = item_i.word_count[7:0];
        run_o.bytes[3] = item_i.word_count[15:8];
        run_o.bytes[4] = header_ecc(item_i.data_type, item_i.word_count[7:0],
                                    item_i.word_count[15:8]);
        remaining_d    = item_i.word_count;
        if (item_i.word_count == 16'd0) begin
          // empty payload: trailer straight after the header
          open_d         = 1'b0;
          run_o.bytes[5] = CRC_BYTE;
          run_o.bytes[6] = CRC_BYTE;
          run_o.bytes[7] = END_BYTE;
          run_o.ends[7]  = 1'b1;
          run_o.last     = RunIdxW'(7);
        end else begin
          open_d     = 1'b1;
          run_o.last = RunIdxW'(4);
        end
      end
      ACT_PAYLOAD: begin
        if (open_q) begin
          has_run_o      = 1'b1;
          remaining_d    = rem_dec;
          run_o.bytes[0] = item_i.data_byte;
          if (rem_dec == 16'd0) begin
            open_d         = 1'b0;
            run_o.bytes[1] = CRC_BYTE;
            run_o.bytes[2] = CRC_BYTE;
            run_o.bytes[3] = END_BYTE;
            run_o.ends[3]  = 1'b1;
            run_o.last     = RunIdxW'(3);
          end
        end
      end
      default: begin
        has_run_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      remaining_q <= '0;
      open_q      <= 1'b0;
    end else if (accept_i) begin
      remaining_q <= remaining_d;
      open_q      <= open_d;
    end
  end

  // an open packet always has payload outstanding
  a_open_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_q == (remaining_q != 16'd0))
    else $error("packet open flag disagrees with byte count");

  // stray payload produces nothing
  a_stray_drop : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_i.action == ACT_PAYLOAD && !open_q) |-> !has_run_o)
    else $error("payload with no open packet produced a run");

endmodule

// ===== design/dpf_serializer.sv =====
// Result register and byte serializer: holds one run and emits a byte per cycle while out_o.ready is high.
// Depends on dpf_pkg and dpf_out_if.
module dpf_serializer
  import dpf_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      load_i,
  input  dpf_run_t  run_i,
  output logic      free_o,
  dpf_out_if.source out_o
);

  logic                busy_q, busy_d;
  logic [RunIdxW-1:0]  idx_q, idx_d;
  dpf_run_t            run_q;
  logic                at_last;
  logic                take;

  assign at_last = (idx_q == run_q.last);
  assign take    = busy_q && out_o.ready;
  // free for a new run when empty, or when the final byte leaves this cycle
  assign free_o  = !busy_q || (out_o.ready && at_last);

  assign out_o.valid      = busy_q;
  assign out_o.out_byte   = run_q.bytes[idx_q];
  assign out_o.packet_end = run_q.ends[idx_q];
  assign out_o.run_last   = at_last;

  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    if (take) begin
      if (at_last) begin
        busy_d = 1'b0;
      end else begin
        idx_d = idx_q + RunIdxW'(1);
      end
    end
    if (load_i) begin
      busy_d = 1'b1;
      idx_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      run_q <= run_i;
    end
  end

  a_idx_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> idx_q <= run_q.last)
    else $error("byte index ran past end of run");

  a_end_is_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && run_q.ends[idx_q]) |-> at_last)
    else $error("packet end flagged before last byte of run");

  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> (!busy_q || (out_o.ready && at_last)))
    else $error("run loaded over one still being sent");

endmodule
